### hdl/fzci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fzci_pkg;

  // Field widths of the streams and the register.
  localparam int unsigned SampleW  = 22;
  localparam int unsigned IndexW   = 16;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned FracOutW = 16;
  localparam int unsigned OffsetW  = 32;

  // Search limits and fixed-point precision of the interpolation.
  localparam int unsigned MaxSamples = 65536;
  localparam int unsigned FracBits   = 16;
  localparam logic [IndexW-1:0] PosCap =
    (MaxSamples > 65536) ? IndexW'(65535) : IndexW'(MaxSamples - 1);

  localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(40000);

  // Queue between front and back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Divider step counter.
  localparam int unsigned DivCntW = $clog2(FracBits + 1);

  // Conversion of the quotient to the 16-bit output fraction.
  localparam int unsigned FracTmpW = (FracBits > FracOutW) ? FracBits : FracOutW;
  localparam int unsigned FracShR  = (FracBits >= FracOutW) ? FracBits - FracOutW : 0;
  localparam int unsigned FracShL  = (FracBits < FracOutW) ? FracOutW - FracBits : 0;

  // One job handed from the front to the back.
  typedef struct packed {
    logic                      found;
    logic [IndexW-1:0]         index;
    logic signed [SampleW-1:0] prev;
    logic signed [SampleW-1:0] cur;
  } job_t;

  function automatic logic [FracOutW-1:0] frac_to_out(input logic [FracBits-1:0] frac);
    logic [FracTmpW-1:0] tmp;
    tmp = FracTmpW'(frac);
    tmp = (tmp >> FracShR) << FracShL;
    return tmp[FracOutW-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/fzci_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fzci_in_if import fzci_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  logic                      first_of_packet;
  logic                      last_of_packet;

  modport source (output valid, sample, first_of_packet, last_of_packet, input ready);
  modport sink   (input valid, sample, first_of_packet, last_of_packet, output ready);
endinterface

`default_nettype wire

### hdl/fzci_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fzci_out_if import fzci_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                found;
  logic [IndexW-1:0]   edge_index;
  logic [FracOutW-1:0] edge_fraction;
  logic [OffsetW-1:0]  edge_offset;

  modport source (output valid, found, edge_index, edge_fraction, edge_offset, input ready);
  modport sink   (input valid, found, edge_index, edge_fraction, edge_offset, output ready);
endinterface

`default_nettype wire

### hdl/fzci_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fzci_cfg_if import fzci_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PeriodW-1:0] period;

  modport source (output valid, period, input ready);
  modport sink   (input valid, period, output ready);
endinterface

`default_nettype wire

### hdl/falling_zero_crossing_interpolator_top.sv
// Finds the first falling zero crossing (previous sample >= 0, current < 0) in each
// packet of signed samples and returns one result per packet: the index of the last
// non-negative sample, the interpolated fraction prev/(prev-cur) in 16 fractional
// bits and the offset (index + fraction) times the sample period, saturated to 32
// bits; a packet without a crossing gives one result with found clear and zero fields.
// Samples are taken one per cycle as long as the two-entry job queue has room. A
// crossing job passes in turn through the job pop, the bit-serial divider (one
// quotient bit per cycle), the multiply and the sum with output load; a not-found
// job skips the divider. The sample period register may be written only while no
// result is pending.
`timescale 1ns / 1ps
`default_nettype none

module falling_zero_crossing_interpolator_top import fzci_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fzci_in_if.sink    in_if,
  fzci_out_if.source out_if,
  fzci_cfg_if.sink   cfg_if
);

  logic [PeriodW-1:0] period_q;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;
  job_t               push_job;
  job_t               pop_job;

  // Sample period register; every transfer on the configuration channel writes it.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
    end else if (cfg_if.valid) begin
      period_q <= cfg_if.period;
    end
  end

  fzci_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if    (in_if),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job)
  );

  fzci_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (pop_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  fzci_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .period_i  (period_q),
    .job_i     (pop_job),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .out_if    (out_if)
  );

  // The front never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_full)
    else $error("job pushed into a full queue");

  // The back never takes a job from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_empty)
    else $error("job taken from an empty queue");

  // A not-found result carries zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.found) |->
      (out_if.edge_index == '0 && out_if.edge_fraction == '0 && out_if.edge_offset == '0))
    else $error("not-found result with non-zero fields");

  // A crossing index always lies below the index cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.found) |-> (out_if.edge_index < PosCap))
    else $error("crossing index beyond cap");

endmodule

`default_nettype wire

### hdl/fzci_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fzci_front import fzci_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  fzci_in_if.sink      in_if,
  input  wire logic    q_full_i,
  output      logic    push_o,
  output      job_t    job_o
);

  logic signed [SampleW-1:0] prev_q, prev_d;
  logic [IndexW-1:0]         pos_q, pos_d;
  logic                      seen_q, seen_d;
  logic                      open_q, open_d;

  logic xfer;
  logic start;
  logic hit;
  logic miss;

  assign in_if.ready = !q_full_i;
  assign xfer        = in_if.valid && in_if.ready;

  // Classify the sample: a new packet, a first falling crossing, or a packet end
  // with nothing found.
  assign start = in_if.first_of_packet || !open_q;
  assign hit   = !start && (pos_q < PosCap) && !seen_q && !prev_q[SampleW-1]
                 && in_if.sample[SampleW-1];
  assign miss  = in_if.last_of_packet && (start || !seen_q) && !hit;

  assign push_o       = xfer && (hit || miss);
  assign job_o.found  = hit;
  assign job_o.index  = pos_q;
  assign job_o.prev   = prev_q;
  assign job_o.cur    = in_if.sample;

  // Search state for the next sample.
  always_comb begin
    prev_d = prev_q;
    pos_d  = pos_q;
    seen_d = seen_q;
    open_d = open_q;
    if (start) begin
      prev_d = in_if.sample;
      pos_d  = '0;
      seen_d = 1'b0;
      open_d = 1'b1;
    end else if (pos_q < PosCap) begin
      prev_d = in_if.sample;
      pos_d  = pos_q + IndexW'(1);
      seen_d = seen_q || hit;
    end
    if (in_if.last_of_packet) begin
      open_d = 1'b0;
      seen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      pos_q  <= '0;
      seen_q <= 1'b0;
      open_q <= 1'b0;
    end else if (xfer) begin
      prev_q <= prev_d;
      pos_q  <= pos_d;
      seen_q <= seen_d;
      open_q <= open_d;
    end
  end

endmodule

`default_nettype wire

### hdl/fzci_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fzci_queue import fzci_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  input  wire logic pop_i,
  output      job_t job_o,
  output      logic full_o,
  output      logic empty_o
);

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  // Pointer arithmetic wraps at the queue depth.
  function automatic logic [QPtrW-1:0] next_ptr(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

### hdl/fzci_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fzci_back import fzci_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [PeriodW-1:0] period_i,
  input  wire job_t               job_i,
  input  wire logic               q_empty_i,
  output      logic               pop_o,
  fzci_out_if.source              out_if
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_MUL  = 4'b0100,
    S_SUM  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic                          found_q;
  logic [IndexW-1:0]             index_q;
  logic [SampleW:0]              rem_q;
  logic [SampleW-1:0]            den_q;
  logic [FracBits-1:0]           quo_q;
  logic [DivCntW-1:0]            cnt_q;
  logic [IndexW+PeriodW-1:0]     prod_hi_q;
  logic [FracBits+PeriodW-1:0]   prod_lo_q;

  logic                          out_valid_q;
  logic                          out_found_q;
  logic [IndexW-1:0]             out_index_q;
  logic [FracOutW-1:0]           out_frac_q;
  logic [OffsetW-1:0]            out_offset_q;

  logic                          load_out;
  logic signed [SampleW:0]       diff;
  logic [SampleW:0]              rem_sh;
  logic                          ge;
  logic [OffsetW:0]              sum;

  assign pop_o    = (state_q == S_IDLE) && !q_empty_i;
  assign load_out = (state_q == S_SUM) && (!out_valid_q || out_if.ready);

  // Denominator prev - cur is positive for a crossing.
  assign diff   = {job_i.prev[SampleW-1], job_i.prev} - {job_i.cur[SampleW-1], job_i.cur};

  // One restoring division step: one quotient bit a cycle.
  assign rem_sh = {rem_q[SampleW-1:0], 1'b0};
  assign ge     = (rem_sh >= {1'b0, den_q});

  // Offset = index * period + floor(fraction * period / 2^FracBits), saturated.
  assign sum = OffsetW'(prod_hi_q) + (OffsetW + 1)'(prod_lo_q >> FracBits);

  // Sequencer of the back part.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          state_d = job_i.found ? S_DIV : S_MUL;
        end
      end
      S_DIV: begin
        if (cnt_q == DivCntW'(FracBits - 1)) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_SUM;
      end
      S_SUM: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      found_q <= job_i.found;
      index_q <= job_i.found ? job_i.index : '0;
      rem_q   <= {1'b0, job_i.prev};
      den_q   <= diff[SampleW-1:0];
      quo_q   <= '0;
      cnt_q   <= '0;
    end
    if (state_q == S_DIV) begin
      rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_q <= {quo_q[FracBits-2:0], ge};
      cnt_q <= cnt_q + DivCntW'(1);
    end
    if (state_q == S_MUL) begin
      prod_hi_q <= index_q * period_i;
      prod_lo_q <= quo_q * period_i;
    end
    if (load_out) begin
      out_found_q  <= found_q;
      out_index_q  <= index_q;
      out_frac_q   <= frac_to_out(quo_q);
      out_offset_q <= sum[OffsetW] ? '1 : sum[OffsetW-1:0];
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.found         = out_found_q;
  assign out_if.edge_index    = out_index_q;
  assign out_if.edge_fraction = out_frac_q;
  assign out_if.edge_offset   = out_offset_q;

endmodule

`default_nettype wire

### bench/fzci_checker.sv
`timescale 1ns / 1ps

// Watches the sample, result and register channels of the interpolator. It keeps
// its own copy of the crossing search and the sample period, works out the expected
// result of each packet from the accepted samples and compares each result transfer
// with the oldest one still waiting.
module fzci_checker import fzci_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  fzci_in_if          in_if,
  fzci_out_if         out_if,
  fzci_cfg_if         cfg_if,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  typedef logic [63:0] wide_t;

  typedef struct packed {
    logic                found;
    logic [IndexW-1:0]   index;
    logic [FracOutW-1:0] fraction;
    logic [OffsetW-1:0]  offset;
  } crossing_t;

  // Copy of the search state and the register.
  logic [PeriodW-1:0]        period;
  logic signed [SampleW-1:0] held_sample;
  logic [IndexW-1:0]         position;
  bit                        crossing_seen;
  bit                        packet_open;
  crossing_t                 crossing_q[$];
  int unsigned               errors;

  // Interpolates between a non-negative sample and the negative one after it and
  // scales the position by the sample period.
  function automatic crossing_t crossing_result(input logic [IndexW-1:0] idx,
                                                input logic signed [SampleW-1:0] prev,
                                                input logic signed [SampleW-1:0] cur,
                                                input logic [PeriodW-1:0] per);
    crossing_t r;
    wide_t     num;
    wide_t     span;
    wide_t     quot;
    wide_t     scaled;
    num    = wide_t'(longint'(prev));
    span   = wide_t'(longint'(prev) - longint'(cur));
    quot   = (num << FracBits) / span;
    scaled = ((wide_t'(idx) << FracBits) + quot) * wide_t'(per);
    scaled = scaled >> FracBits;
    r.found = 1'b1;
    r.index = idx;
    if (FracBits >= FracOutW) begin
      r.fraction = FracOutW'(quot >> (FracBits - FracOutW));
    end else begin
      r.fraction = FracOutW'(quot << (FracOutW - FracBits));
    end
    r.offset = (scaled > wide_t'(32'hFFFF_FFFF)) ? '1 : OffsetW'(scaled);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    crossing_t                 got;
    crossing_t                 want;
    logic signed [SampleW-1:0] cur;
    bit                        produced;
    if (!rst_ni) begin
      period        = PeriodReset;
      held_sample   = '0;
      position      = '0;
      crossing_seen = 1'b0;
      packet_open   = 1'b0;
      crossing_q.delete();
      errors        = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      // A result transfer is matched against the oldest waiting expectation.
      if (out_if.valid && out_if.ready) begin
        got.found    = out_if.found;
        got.index    = out_if.edge_index;
        got.fraction = out_if.edge_fraction;
        got.offset   = out_if.edge_offset;
        if (crossing_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected result found=%0b index=%0d fraction=%0d offset=%0d",
                     $time, got.found, got.index, got.fraction, got.offset);
          end
        end else begin
          want = crossing_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result mismatch, expected found=%0b index=%0d fraction=%0d offset=%0d",
                       $time, want.found, want.index, want.fraction, want.offset);
              $display("%0t:                  actual found=%0b index=%0d fraction=%0d offset=%0d",
                       $time, got.found, got.index, got.fraction, got.offset);
            end
          end
        end
      end

      if (cfg_if.valid && cfg_if.ready) begin
        period = cfg_if.period;
      end

      // Search step for an accepted sample.
      if (in_if.valid && in_if.ready) begin
        cur      = in_if.sample;
        produced = 1'b0;
        if (in_if.first_of_packet || !packet_open) begin
          // A first mark, or a sample with no packet open, restarts the search.
          crossing_seen = 1'b0;
          packet_open   = 1'b1;
          held_sample   = cur;
          position      = '0;
        end else if (position < PosCap) begin
          if (!crossing_seen && held_sample >= 0 && cur < 0) begin
            crossing_q.push_back(crossing_result(position, held_sample, cur, period));
            crossing_seen = 1'b1;
            produced      = 1'b1;
          end
          held_sample = cur;
          position    = position + 1'b1;
        end
        // Past the index limit nothing is searched, but a last mark still closes.
        if (in_if.last_of_packet) begin
          if (!crossing_seen && !produced) begin
            crossing_q.push_back('0);
          end
          packet_open   = 1'b0;
          crossing_seen = 1'b0;
        end
      end

      mismatch_count_o <= errors;
      pending_o        <= crossing_q.size();
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top import fzci_pkg::*; ();

  localparam int unsigned ClkHalf         = 5;
  localparam int unsigned ResetCycles     = 7;
  localparam int unsigned SettleCycles    = 30;
  localparam int unsigned WatchdogLimit   = 2000;
  localparam int unsigned PhaseCount      = 6;
  localparam int unsigned ItemsPerPhase   = 300;
  localparam logic signed [SampleW-1:0] SampleMax = SampleW'((1 << (SampleW - 1)) - 1);

  typedef enum int unsigned {StallNone, StallRandom, StallPeriodic, StallLong} stall_mode_e;
  typedef enum int unsigned {PktCrossing, PktNoCrossing, PktNoise} packet_kind_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned idle_cycles;

  fzci_in_if  sample_bus ();
  fzci_out_if edge_bus ();
  fzci_cfg_if cfg_bus ();

  falling_zero_crossing_interpolator_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (sample_bus),
    .out_if (edge_bus),
    .cfg_if (cfg_bus)
  );

  fzci_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_if            (sample_bus),
    .out_if           (edge_bus),
    .cfg_if           (cfg_bus),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always #(ClkHalf) clk = ~clk;

  // Result back-pressure: stretches of different stall patterns, some with none.
  initial begin
    stall_mode_e mode;
    int unsigned span;
    int unsigned cycle_len;
    int unsigned low_len;
    edge_bus.ready <= 1'b0;
    forever begin
      mode      = stall_mode_e'($urandom_range(0, 3));
      span      = $urandom_range(50, 400);
      cycle_len = $urandom_range(2, 9);
      low_len   = $urandom_range(1, cycle_len - 1);
      for (int unsigned c = 0; c < span; c++) begin
        @(posedge clk);
        case (mode)
          StallNone:     edge_bus.ready <= 1'b1;
          StallRandom:   edge_bus.ready <= ($urandom_range(0, 3) != 0);
          StallPeriodic: edge_bus.ready <= ((c % cycle_len) >= low_len);
          default:       edge_bus.ready <= ((c % 24) >= 18);
        endcase
      end
    end
  end

  // Ends the run if no transfer happens on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (sample_bus.valid && sample_bus.ready) || (edge_bus.valid && edge_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("falling_zero_crossing_interpolator_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Random sample level: magnitudes spread over all bit widths, full scale now and then.
  function automatic logic signed [SampleW-1:0] pick_level(input bit negative);
    int unsigned width_bits;
    int unsigned mag;
    width_bits = $urandom_range(1, SampleW - 1);
    mag = $urandom & ((32'd1 << width_bits) - 1);
    if ($urandom_range(0, 15) == 0) begin
      mag = SampleMax;
    end
    if (negative) begin
      if (mag == 0) begin
        mag = 1;
      end
      return SampleW'(-int'(mag));
    end
    return SampleW'(mag);
  endfunction

  // One sample transfer; the sender idles in random gaps between bursts.
  task automatic put_sample(input logic signed [SampleW-1:0] value, input bit is_first,
                            input bit is_last);
    int unsigned gap;
    int unsigned roll;
    sample_bus.valid           <= 1'b1;
    sample_bus.sample          <= value;
    sample_bus.first_of_packet <= is_first;
    sample_bus.last_of_packet  <= is_last;
    do @(posedge clk); while (!sample_bus.ready);
    items_sent++;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      roll = $urandom_range(0, 19);
      gap  = (roll < 8) ? 0 : (roll < 18) ? $urandom_range(1, 6) : $urandom_range(12, 30);
      if (gap != 0) begin
        sample_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Mostly well-formed packets with at least one falling edge, some without, some noise.
  task automatic send_packet();
    packet_kind_e kind;
    int unsigned  pick;
    int unsigned  style;
    int unsigned  len;
    int unsigned  cross_at;
    bit           neg;
    bit           is_first;
    bit           is_last;
    pick     = $urandom_range(0, 9);
    kind     = (pick < 6) ? PktCrossing : (pick < 8) ? PktNoCrossing : PktNoise;
    style    = $urandom_range(0, 2);
    len      = (kind == PktCrossing) ? $urandom_range(2, 24) :
               (kind == PktNoCrossing) ? $urandom_range(1, 16) : $urandom_range(1, 8);
    cross_at = (kind == PktCrossing) ? $urandom_range(1, len - 1) : $urandom_range(0, len);
    for (int unsigned i = 0; i < len; i++) begin
      case (kind)
        PktCrossing:   neg = (i == cross_at) || (i > cross_at && $urandom_range(0, 1) == 1);
        PktNoCrossing: neg = (style == 0) || (style == 2 && i < cross_at);
        default:       neg = $urandom_range(0, 1);
      endcase
      if (kind == PktNoise) begin
        is_first = ($urandom_range(0, 3) == 0);
        is_last  = ($urandom_range(0, 3) == 0);
      end else begin
        is_first = (i == 0) && ($urandom_range(0, 9) != 0);
        is_last  = (i == len - 1) && ($urandom_range(0, 9) != 0);
      end
      put_sample(pick_level(neg), is_first, is_last);
    end
  endtask

  // Holds the sender until every expected result has come and the block is quiet.
  task automatic drain_results();
    sample_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_period(input logic [PeriodW-1:0] value);
    cfg_bus.valid  <= 1'b1;
    cfg_bus.period <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    logic [PeriodW-1:0] period_value;
    int unsigned        phase_start;
    sample_bus.valid           <= 1'b0;
    sample_bus.sample          <= '0;
    sample_bus.first_of_packet <= 1'b0;
    sample_bus.last_of_packet  <= 1'b0;
    cfg_bus.valid              <= 1'b0;
    cfg_bus.period             <= '0;
    items_sent = 0;
    burst_left = 1;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset sample period.
    // No packet open after reset: the sample opens one; zero counts as non-negative
    // and the edge falls on the last sample.
    put_sample(0, 1'b0, 1'b0);
    put_sample(-1, 1'b0, 1'b1);
    // Single-sample packet.
    put_sample(5, 1'b1, 1'b1);
    // Full-scale swing, then a further edge in the same packet that is ignored.
    put_sample(SampleMax, 1'b1, 1'b0);
    put_sample(-SampleMax, 1'b0, 1'b0);
    put_sample(10, 1'b0, 1'b0);
    put_sample(-10, 1'b0, 1'b1);
    // A first mark inside an open packet drops the old one.
    put_sample(3, 1'b1, 1'b0);
    put_sample(4, 1'b0, 1'b0);
    put_sample(-5, 1'b1, 1'b0);
    put_sample(7, 1'b0, 1'b0);
    put_sample(-8, 1'b0, 1'b1);
    // Packets without an edge: all negative, then all non-negative.
    put_sample(-1, 1'b1, 1'b0);
    put_sample(-2, 1'b0, 1'b0);
    put_sample(-SampleMax, 1'b0, 1'b1);
    put_sample(SampleMax, 1'b1, 1'b0);
    put_sample(1, 1'b0, 1'b1);
    // After a last mark, a sample without a first mark opens a new packet.
    put_sample(1, 1'b0, 1'b0);
    put_sample(-SampleMax, 1'b0, 1'b1);
    // Smallest step across zero: an exact half.
    put_sample(1, 1'b1, 1'b0);
    put_sample(-1, 1'b0, 1'b1);

    // Random phases, each at its own sample period, extremes first.
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0:       period_value = '0;
        1:       period_value = '1;
        2:       period_value = 1;
        default: period_value = PeriodW'($urandom_range(0, (1 << PeriodW) - 1));
      endcase
      drain_results();
      write_period(period_value);
      phase_start = items_sent;
      while (items_sent - phase_start < ItemsPerPhase) begin
        send_packet();
      end
    end

    drain_results();
    if (mismatches == 0 && pending == 0) begin
      $display("falling_zero_crossing_interpolator_top test passed");
    end else begin
      $display("falling_zero_crossing_interpolator_top test failed");
    end
    $finish;
  end

endmodule
